[rtl/rbsl_pkg.sv]
// Shared types and constants for the reset button and status LED supervisor.
package rbsl_pkg;

  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CountW  = 8;
  localparam int unsigned BlinkW  = 4;

  localparam logic [CfgIdxW-1:0] CfgHoldTicks = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHkDivide  = 1'd1;

  localparam logic [CfgW-1:0] HoldTicksRst = 8'd30;
  localparam logic [CfgW-1:0] HkDivideRst  = 8'd10;

  localparam logic [BlinkW-1:0] BlinkLast  = 4'd9;
  localparam logic [BlinkW-1:0] BlinkDark0 = 4'd0;
  localparam logic [BlinkW-1:0] BlinkDark1 = 4'd5;
  localparam logic [BlinkW-1:0] BlinkDark2 = 4'd6;

  typedef struct packed {
    logic button_level;
    logic wan_enabled;
    logic wan_link;
    logic wan_disconnected;
    logic wan_auto_mode;
    logic dhcp_server_running;
  } in_item_t;

  typedef struct packed {
    logic power_led_on;
    logic wan_led_on;
    logic fast_tick;
    logic factory_reset;
    logic dhcp_restart;
    logic housekeeping_due;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

[rtl/rbsl_in_if.sv]
// Input transaction channel carrying one timer tick with button and WAN status.
interface rbsl_in_if import rbsl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rbsl_out_if.sv]
// Output transaction channel carrying one LED and request result.
interface rbsl_out_if import rbsl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rbsl_core.sv]
// Supervisor state, configuration registers and per-tick update logic.
module rbsl_core import rbsl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               step_i,
  input  in_item_t           item_i,
  output step_res_t          res_o
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhPressed = 2'd1,
    PhArmed   = 2'd2,
    PhHalted  = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   hold_q, hold_d;
  logic [BlinkW-1:0]   blink_q, blink_d;
  logic                fast_q, fast_d;
  logic                pwr_q, pwr_d;
  logic                wled_q, wled_d;
  logic                wblink_q, wblink_d;
  logic                wup_q, wup_d;
  logic                llink_q, llink_d;
  logic [CountW-1:0]   div_q, div_d;
  logic [CfgW-1:0]     hold_ticks_q;
  logic [CfgW-1:0]     hk_div_q;
  logic                pressed, skip, freset, rs, hk;
  logic [CountW:0]     div_inc;
  out_item_t           item;

  always_comb begin
    phase_d  = phase_q;
    hold_d   = hold_q;
    blink_d  = blink_q;
    fast_d   = fast_q;
    pwr_d    = pwr_q;
    wled_d   = wled_q;
    wblink_d = wblink_q;
    wup_d    = wup_q;
    llink_d  = llink_q;
    div_d    = div_q;
    freset   = 1'b0;
    rs       = 1'b0;
    hk       = 1'b0;
    skip     = 1'b0;
    pressed  = !item_i.button_level;
    div_inc  = {1'b0, div_q} + {{CountW{1'b0}}, 1'b1};
    item     = '0;

    if (phase_q == PhHalted) begin
      item.power_led_on = pwr_q;
      item.wan_led_on   = wled_q;
    end else begin
      if (pressed) begin
        if (phase_q == PhIdle) begin
          phase_d = PhPressed;
          hold_d  = '0;
          blink_d = '0;
          fast_d  = 1'b1;
        end else begin
          if (hold_q >= hold_ticks_q) begin
            phase_d = PhArmed;
          end else begin
            hold_d = hold_q + CountW'(1);
          end
          blink_d = (blink_q >= BlinkLast) ? '0 : blink_q + BlinkW'(1);
          if (phase_d == PhArmed) begin
            pwr_d = !(blink_d == BlinkDark0 || blink_d == BlinkDark1 ||
                      blink_d == BlinkDark2);
          end
        end
      end else if (phase_q == PhPressed) begin
        hold_d  = '0;
        phase_d = PhIdle;
        pwr_d   = 1'b1;
        fast_d  = 1'b0;
      end else if (phase_q == PhArmed) begin
        phase_d = PhHalted;
        fast_d  = 1'b0;
        freset  = 1'b1;
        skip    = 1'b1;
      end

      if (phase_d == PhIdle) begin
        pwr_d = 1'b1;
      end
      if (fast_d) begin
        skip = 1'b1;
      end

      if (!skip) begin
        if (item_i.wan_enabled) begin
          if (!item_i.wan_link || item_i.wan_disconnected) begin
            wup_d    = 1'b0;
            wblink_d = !wblink_q;
            wled_d   = wblink_q;
          end else begin
            if (!wup_q) begin
              wled_d = 1'b1;
            end
            wup_d = 1'b1;
          end
          if (item_i.wan_link != llink_q) begin
            rs      = item_i.wan_link && item_i.wan_auto_mode && !item_i.dhcp_server_running;
            llink_d = item_i.wan_link;
          end
        end
        if (div_inc >= {1'b0, hk_div_q}) begin
          div_d = '0;
        end else begin
          div_d = div_inc[CountW-1:0];
        end
        hk = (div_d == '0);
      end

      item.power_led_on     = pwr_d;
      item.wan_led_on       = wled_d;
      item.fast_tick        = fast_d;
      item.factory_reset    = freset;
      item.dhcp_restart     = rs;
      item.housekeeping_due = hk;
    end
  end

  assign res_o.valid = step_i;
  assign res_o.item  = item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      hold_q       <= '0;
      blink_q      <= '0;
      fast_q       <= 1'b0;
      pwr_q        <= 1'b1;
      wled_q       <= 1'b0;
      wblink_q     <= 1'b0;
      wup_q        <= 1'b0;
      llink_q      <= 1'b0;
      div_q        <= '0;
      hold_ticks_q <= HoldTicksRst;
      hk_div_q     <= HkDivideRst;
    end else begin
      if (step_i) begin
        phase_q  <= phase_d;
        hold_q   <= hold_d;
        blink_q  <= blink_d;
        fast_q   <= fast_d;
        pwr_q    <= pwr_d;
        wled_q   <= wled_d;
        wblink_q <= wblink_d;
        wup_q    <= wup_d;
        llink_q  <= llink_d;
        div_q    <= div_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgHoldTicks: hold_ticks_q <= cfg_wdata_i;
          CfgHkDivide:  hk_div_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[rtl/rbsl_out_stage.sv]
// Result register that holds one finished transaction until the sink takes it.
module rbsl_out_stage import rbsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  step_res_t   res_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        ready_i,
  output out_item_t   data_o
);

  logic      valid_q;
  out_item_t data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_i.valid) begin
      data_q <= res_i.item;
    end
  end

endmodule

[rtl/reset_button_and_status_led_supervisor.sv]
// Latency: a result is registered and appears in the cycle after its tick transaction is accepted.
// Throughput: one transaction per cycle; the single result register passes
// a new result whenever it is empty or being drained in the same cycle.
// Reset: asynchronous, active low; LEDs power on lit, WAN dark, slow ticks,
// hold_ticks 30 and housekeeping_divide 10.
module reset_button_and_status_led_supervisor import rbsl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  rbsl_in_if.sink            in_i,
  rbsl_out_if.source         out_o
);

  logic      step;
  logic      stage_ready;
  step_res_t res;

  assign in_i.ready = stage_ready;
  assign step       = in_i.valid && stage_ready;

  rbsl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (in_i.data),
    .res_o       (res)
  );

  rbsl_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .ready_o (stage_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.data)
  );

endmodule
